// File: rtl/hs_pkg.sv
package hs_pkg;

    localparam int VAL_W  = 32;
    localparam int STAT_W = 2;

    localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY    = 2'd1;
    localparam logic [STAT_W-1:0] STAT_OVERFLOW = 2'd2;

    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_OVERFLOW,
        CMD_EMPTY,
        CMD_SORT_START,
        CMD_BUILD_RD,
        CMD_CUR_TAKE,
        CMD_LEFT,
        CMD_RIGHT,
        CMD_CMP,
        CMD_DECIDE,
        CMD_X_RD,
        CMD_X_ROOT,
        CMD_X_LAST,
        CMD_SORT_END,
        CMD_FETCH_RD,
        CMD_FETCH_TAKE,
        CMD_EMIT
    } hs_cmd_t;

    typedef struct packed {
        logic load_op;
        logic draining;
        logic count_zero;
        logic full;
        logic k_zero;
        logic hs_gt1;
        logic left_in;
        logic right_in;
        logic child_big;
        logic out_free;
    } hs_stat_t;

endpackage

// File: rtl/hs_ram.sv
module hs_ram
#(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
)
(
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/hs_ctrl.sv
module hs_ctrl
    import hs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     s_axis_tvalid,
    output logic     s_axis_tready,
    input  hs_stat_t stat,
    output hs_cmd_t  cmd
);

    typedef enum logic [11:0] {
        S_IDLE   = 12'b0000_0000_0001,
        S_BUILD  = 12'b0000_0000_0010,
        S_CUR    = 12'b0000_0000_0100,
        S_LEFT   = 12'b0000_0000_1000,
        S_RIGHT  = 12'b0000_0001_0000,
        S_CMP    = 12'b0000_0010_0000,
        S_DECIDE = 12'b0000_0100_0000,
        S_XNEXT  = 12'b0000_1000_0000,
        S_XROOT  = 12'b0001_0000_0000,
        S_XLAST  = 12'b0010_0000_0000,
        S_FETCH  = 12'b0100_0000_0000,
        S_EMIT   = 12'b1000_0000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   build_reg, build_next;
    state_t sink_ret;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign sink_ret      = build_reg ? S_BUILD : S_XNEXT;

    always_comb
    begin
        state_next = state_reg;
        build_next = build_reg;
        cmd        = CMD_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    if (stat.load_op)
                    begin
                        if (stat.draining || !stat.full)
                        begin
                            cmd = CMD_LOAD;
                        end
                        else
                        begin
                            cmd        = CMD_OVERFLOW;
                            state_next = S_EMIT;
                        end
                    end
                    else if (stat.draining)
                    begin
                        cmd        = CMD_FETCH_RD;
                        state_next = S_FETCH;
                    end
                    else if (stat.count_zero)
                    begin
                        cmd        = CMD_EMPTY;
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        cmd        = CMD_SORT_START;
                        build_next = 1'b1;
                        state_next = S_BUILD;
                    end
                end
            end
            S_BUILD:
            begin
                if (stat.k_zero)
                begin
                    build_next = 1'b0;
                    state_next = S_XNEXT;
                end
                else
                begin
                    cmd        = CMD_BUILD_RD;
                    state_next = S_CUR;
                end
            end
            S_CUR:
            begin
                cmd        = CMD_CUR_TAKE;
                state_next = S_LEFT;
            end
            S_LEFT:
            begin
                cmd        = CMD_LEFT;
                state_next = stat.left_in ? S_RIGHT : sink_ret;
            end
            S_RIGHT:
            begin
                cmd        = CMD_RIGHT;
                state_next = stat.right_in ? S_CMP : S_DECIDE;
            end
            S_CMP:
            begin
                cmd        = CMD_CMP;
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                cmd        = CMD_DECIDE;
                state_next = stat.child_big ? S_LEFT : sink_ret;
            end
            S_XNEXT:
            begin
                if (stat.hs_gt1)
                begin
                    cmd        = CMD_X_RD;
                    state_next = S_XROOT;
                end
                else
                begin
                    cmd        = CMD_SORT_END;
                    state_next = S_FETCH;
                end
            end
            S_XROOT:
            begin
                cmd        = CMD_X_ROOT;
                state_next = S_XLAST;
            end
            S_XLAST:
            begin
                cmd        = CMD_X_LAST;
                state_next = S_LEFT;
            end
            S_FETCH:
            begin
                cmd        = CMD_FETCH_TAKE;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd        = CMD_EMIT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
                build_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            build_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            build_reg <= build_next;
        end
    end

endmodule

// File: rtl/hs_dp.sv
module hs_dp
    import hs_pkg::*;
#(
    parameter int CAPACITY = 1024
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  hs_cmd_t           cmd,
    output hs_stat_t          stat,
    input  logic [VAL_W-1:0]  s_axis_tdata,
    input  logic              s_axis_tuser,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [VAL_W-1:0]  m_axis_tdata,
    output logic              m_axis_tlast,
    output logic [STAT_W-1:0] m_axis_tuser
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int LW = AW + 2;

    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] hs_reg, hs_next;
    logic [CW-1:0] rp_reg, rp_next;
    logic [CW-1:0] k_reg, k_next;
    logic          draining_reg, draining_next;
    logic [AW-1:0] i_reg, i_next;

    logic signed [VAL_W-1:0] cur_reg, cur_next;
    logic signed [VAL_W-1:0] best_val_reg, best_val_next;
    logic signed [VAL_W-1:0] root_reg, root_next;
    logic [AW-1:0]           best_idx_reg, best_idx_next;
    logic                    best_child_reg, best_child_next;

    logic [VAL_W-1:0]  res_value_reg, res_value_next;
    logic              res_last_reg, res_last_next;
    logic [STAT_W-1:0] res_status_reg, res_status_next;

    logic              out_valid_reg, out_valid_next;
    logic [VAL_W-1:0]  out_value_reg, out_value_next;
    logic              out_last_reg, out_last_next;
    logic [STAT_W-1:0] out_status_reg, out_status_next;

    logic                    wr_en, rd_en;
    logic [AW-1:0]           wr_addr, rd_addr;
    logic [VAL_W-1:0]        wr_data;
    logic [VAL_W-1:0]        rd_data;
    logic signed [VAL_W-1:0] rd_val;

    logic [LW-1:0] l_wide, r_wide, hs_wide;
    logic [CW-1:0] k_dec, rp_inc;
    logic          left_in, right_in, full, out_free;

    hs_ram #(
        .WIDTH (VAL_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign rd_val   = $signed(rd_data);
    assign l_wide   = {1'b0, i_reg, 1'b1};
    assign r_wide   = l_wide + LW'(1);
    assign hs_wide  = LW'(hs_reg);
    assign left_in  = (l_wide < hs_wide);
    assign right_in = (r_wide < hs_wide);
    assign k_dec    = k_reg - CW'(1);
    assign rp_inc   = rp_reg + CW'(1);
    assign full     = (count_reg >= CW'(CAPACITY));
    assign out_free = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        stat.load_op    = !s_axis_tuser;
        stat.draining   = draining_reg;
        stat.count_zero = (count_reg == '0);
        stat.full       = full;
        stat.k_zero     = (k_reg == '0);
        stat.hs_gt1     = (hs_reg > CW'(1));
        stat.left_in    = left_in;
        stat.right_in   = right_in;
        stat.child_big  = best_child_reg;
        stat.out_free   = out_free;
    end

    always_comb
    begin
        count_next      = count_reg;
        hs_next         = hs_reg;
        rp_next         = rp_reg;
        k_next          = k_reg;
        draining_next   = draining_reg;
        i_next          = i_reg;
        cur_next        = cur_reg;
        best_val_next   = best_val_reg;
        best_idx_next   = best_idx_reg;
        best_child_next = best_child_reg;
        root_next       = root_reg;
        res_value_next  = res_value_reg;
        res_last_next   = res_last_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_value_next  = out_value_reg;
        out_last_next   = out_last_reg;
        out_status_next = out_status_reg;
        wr_en           = 1'b0;
        wr_addr         = i_reg;
        wr_data         = cur_reg;
        rd_en           = 1'b0;
        rd_addr         = '0;
        case (cmd)
            CMD_LOAD:
            begin
                wr_en   = 1'b1;
                wr_data = s_axis_tdata;
                if (draining_reg)
                begin
                    wr_addr       = '0;
                    draining_next = 1'b0;
                    count_next    = CW'(1);
                    rp_next       = '0;
                    hs_next       = '0;
                end
                else
                begin
                    wr_addr    = count_reg[AW-1:0];
                    count_next = count_reg + CW'(1);
                end
            end
            CMD_OVERFLOW:
            begin
                res_value_next  = '0;
                res_last_next   = 1'b0;
                res_status_next = STAT_OVERFLOW;
            end
            CMD_EMPTY:
            begin
                res_value_next  = '0;
                res_last_next   = 1'b0;
                res_status_next = STAT_EMPTY;
            end
            CMD_SORT_START:
            begin
                hs_next = count_reg;
                k_next  = count_reg >> 1;
            end
            CMD_BUILD_RD:
            begin
                k_next  = k_dec;
                i_next  = k_dec[AW-1:0];
                rd_en   = 1'b1;
                rd_addr = k_dec[AW-1:0];
            end
            CMD_CUR_TAKE:
            begin
                cur_next = rd_val;
            end
            CMD_LEFT:
            begin
                if (left_in)
                begin
                    rd_en   = 1'b1;
                    rd_addr = l_wide[AW-1:0];
                end
                else
                begin
                    wr_en = 1'b1;
                end
            end
            CMD_RIGHT:
            begin
                if (rd_val > cur_reg)
                begin
                    best_val_next   = rd_val;
                    best_idx_next   = l_wide[AW-1:0];
                    best_child_next = 1'b1;
                end
                else
                begin
                    best_val_next   = cur_reg;
                    best_child_next = 1'b0;
                end
                if (right_in)
                begin
                    rd_en   = 1'b1;
                    rd_addr = r_wide[AW-1:0];
                end
            end
            CMD_CMP:
            begin
                if (rd_val > best_val_reg)
                begin
                    best_val_next   = rd_val;
                    best_idx_next   = r_wide[AW-1:0];
                    best_child_next = 1'b1;
                end
            end
            CMD_DECIDE:
            begin
                wr_en = 1'b1;
                if (best_child_reg)
                begin
                    wr_data = best_val_reg;
                    i_next  = best_idx_reg;
                end
            end
            CMD_X_RD:
            begin
                hs_next = hs_reg - CW'(1);
                rd_en   = 1'b1;
                rd_addr = '0;
            end
            CMD_X_ROOT:
            begin
                root_next = rd_val;
                rd_en     = 1'b1;
                rd_addr   = hs_reg[AW-1:0];
            end
            CMD_X_LAST:
            begin
                cur_next = rd_val;
                wr_en    = 1'b1;
                wr_addr  = hs_reg[AW-1:0];
                wr_data  = root_reg;
                i_next   = '0;
            end
            CMD_SORT_END:
            begin
                hs_next       = '0;
                draining_next = 1'b1;
                rp_next       = '0;
                rd_en         = 1'b1;
                rd_addr       = '0;
            end
            CMD_FETCH_RD:
            begin
                rd_en   = 1'b1;
                rd_addr = rp_reg[AW-1:0];
            end
            CMD_FETCH_TAKE:
            begin
                if (rp_reg >= count_reg)
                begin
                    res_value_next  = '0;
                    res_last_next   = 1'b0;
                    res_status_next = STAT_EMPTY;
                    draining_next   = 1'b0;
                    count_next      = '0;
                    rp_next         = '0;
                end
                else
                begin
                    res_value_next  = rd_data;
                    res_status_next = STAT_OK;
                    res_last_next   = (rp_inc >= count_reg);
                    rp_next         = rp_inc;
                    if (rp_inc >= count_reg)
                    begin
                        draining_next = 1'b0;
                        count_next    = '0;
                        rp_next       = '0;
                    end
                end
            end
            CMD_EMIT:
            begin
                out_valid_next  = 1'b1;
                out_value_next  = res_value_reg;
                out_last_next   = res_last_reg;
                out_status_next = res_status_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            hs_reg         <= '0;
            rp_reg         <= '0;
            k_reg          <= '0;
            draining_reg   <= 1'b0;
            best_child_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            count_reg      <= count_next;
            hs_reg         <= hs_next;
            rp_reg         <= rp_next;
            k_reg          <= k_next;
            draining_reg   <= draining_next;
            best_child_reg <= best_child_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg          <= i_next;
        cur_reg        <= cur_next;
        best_val_reg   <= best_val_next;
        best_idx_reg   <= best_idx_next;
        root_reg       <= root_next;
        res_value_reg  <= res_value_next;
        res_last_reg   <= res_last_next;
        res_status_reg <= res_status_next;
        out_value_reg  <= out_value_next;
        out_last_reg   <= out_last_next;
        out_status_reg <= out_status_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_value_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_status_reg;

    a_emit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd == CMD_EMIT |-> (!out_valid_reg || m_axis_tready))
        else $error("result overwrites a pending beat");

    a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd == CMD_EMIT |=> out_valid_reg)
        else $error("emitted result not presented");

    a_heap_bound: assert property (@(posedge clk) disable iff (!rst_n)
        hs_reg <= count_reg)
        else $error("heap size exceeds loaded count");

    a_drain_ptr: assert property (@(posedge clk) disable iff (!rst_n)
        draining_reg |-> rp_reg < count_reg)
        else $error("read pointer past loaded count while draining");

    a_sink_node: assert property (@(posedge clk) disable iff (!rst_n)
        cmd == CMD_LEFT |-> LW'(i_reg) < hs_wide)
        else $error("sift node outside heap");

endmodule

// File: rtl/heap_sorter.sv
// Heapsort engine for signed 32-bit values.
// Input stream: s_axis_tuser selects the operation (0 load, 1 pull),
// s_axis_tdata carries the value to load. Output stream: m_axis_tdata is
// the sorted value, m_axis_tlast marks the final value of the set and
// m_axis_tuser is the status (0 ok, 1 empty pull, 2 load dropped, full).
// A load that is taken gives no beat; a load into a full store that is
// not draining gives an overflow beat, and a load while draining discards
// the unread set. The first pull sorts the store in place: build-heap,
// then one extraction per value but the last, each sift level reading
// the children through the single read port of the store. Every later pull
// reads the store, then goes through the result and output registers.
// Items are handled one at a time; s_axis_tready is high only while the
// block waits for input. A stalled output holds its beat, and the next
// result waits for the output register to free up.
// Reset empties the set and the output; no memory clearing pass is needed.
module heap_sorter
    import hs_pkg::*;
#(
    parameter int CAPACITY = 1024
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [VAL_W-1:0]  s_axis_tdata,  // [31:0] sort_value
    input  logic              s_axis_tuser,  // [0] operation
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [VAL_W-1:0]  m_axis_tdata,  // [31:0] sorted_value
    output logic              m_axis_tlast,
    output logic [STAT_W-1:0] m_axis_tuser   // [1:0] status
);

    hs_cmd_t  cmd;
    hs_stat_t stat;

    hs_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .stat          (stat),
        .cmd           (cmd)
    );

    hs_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

// File: verif/tb_heap_sorter.sv
`timescale 1ns / 100ps

module tb_heap_sorter;
    import hs_pkg::*;

    localparam int CAPACITY     = 1024;
    localparam int RANDOM_ITEMS = 360;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_PULL = 1'b1;

    localparam int MODE_WIDE    = 0;
    localparam int MODE_NARROW  = 1;
    localparam int MODE_EXTREME = 2;
    localparam int MODE_MIXED   = 3;

    typedef logic signed [VAL_W-1:0] sval_t;

    localparam sval_t VAL_MAX = 32'sh7FFF_FFFF;
    localparam sval_t VAL_MIN = 32'sh8000_0000;

    typedef struct packed {
        sval_t             value;
        logic              last;
        logic [STAT_W-1:0] status;
    } sorted_beat_t;

    logic              clk;
    logic              rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [VAL_W-1:0]  s_axis_tdata;
    logic              s_axis_tuser;
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [VAL_W-1:0]  m_axis_tdata;
    logic              m_axis_tlast;
    logic [STAT_W-1:0] m_axis_tuser;

    heap_sorter #(
        .CAPACITY(CAPACITY)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast),
        .m_axis_tuser (m_axis_tuser)
    );

    // predictor state
    sval_t        held_vals [CAPACITY];
    int           held_count;
    int           drain_idx;
    bit           drain_phase;
    sorted_beat_t expected_sorted [$];

    int mismatch_count;
    int items_sent;
    int quiet_left;

    initial clk = 1'b0;
    always #10 clk = ~clk;

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    function automatic void order_held_set();
        sval_t key;
        int    j;
        for (int i = 1; i < held_count; i++)
        begin
            key = held_vals[i];
            j   = i - 1;
            while (j >= 0 && held_vals[j] > key)
            begin
                held_vals[j + 1] = held_vals[j];
                j--;
            end
            held_vals[j + 1] = key;
        end
    endfunction

    task automatic predict_heapsort(input logic op, input sval_t val);
        sorted_beat_t beat;
        beat = '0;
        if (op == OP_LOAD)
        begin
            if (drain_phase)
            begin
                drain_phase = 1'b0;
                held_count  = 0;
                drain_idx   = 0;
            end
            if (held_count >= CAPACITY)
            begin
                beat.status = STAT_OVERFLOW;
                expected_sorted.push_back(beat);
            end
            else
            begin
                held_vals[held_count] = val;
                held_count++;
            end
        end
        else if (!drain_phase && held_count == 0)
        begin
            beat.status = STAT_EMPTY;
            expected_sorted.push_back(beat);
        end
        else
        begin
            if (!drain_phase)
            begin
                order_held_set();
                drain_phase = 1'b1;
                drain_idx   = 0;
            end
            beat.status = STAT_OK;
            beat.value  = held_vals[drain_idx];
            drain_idx++;
            if (drain_idx >= held_count)
            begin
                beat.last   = 1'b1;
                drain_phase = 1'b0;
                held_count  = 0;
                drain_idx   = 0;
            end
            expected_sorted.push_back(beat);
        end
    endtask

    function automatic int pick_gap();
        int r;
        if (quiet_left > 0)
        begin
            quiet_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            quiet_left = $urandom_range(20, 60);
            return 0;
        end
        if (r < 45)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic sval_t pick_value(input int mode);
        int m;
        m = (mode == MODE_MIXED) ? $urandom_range(MODE_WIDE, MODE_EXTREME) : mode;
        if (m == MODE_NARROW)
            return sval_t'($urandom_range(0, 8)) - 4;
        if (m == MODE_EXTREME)
        begin
            case ($urandom_range(0, 6))
                0: return VAL_MIN;
                1: return VAL_MAX;
                2: return VAL_MIN + 1;
                3: return VAL_MAX - 1;
                4: return -1;
                5: return 1;
                default: return 0;
            endcase
        end
        return sval_t'($urandom);
    endfunction

    task automatic sorter_send(input logic op, input sval_t val);
        int gap;
        gap = pick_gap();
        repeat (gap)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= val;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predict_heapsort(op, val);
        items_sent++;
    endtask

    task automatic load_set(input int count, input int mode);
        repeat (count)
            sorter_send(OP_LOAD, pick_value(mode));
    endtask

    task automatic pull_beats(input int count);
        repeat (count)
            sorter_send(OP_PULL, sval_t'($urandom));
    endtask

    task automatic test_empty_pull();
        pull_beats(2);
    endtask

    task automatic test_single_value();
        sorter_send(OP_LOAD, -5);
        pull_beats(2);
    endtask

    task automatic test_extreme_values();
        sorter_send(OP_LOAD, VAL_MAX);
        sorter_send(OP_LOAD, VAL_MIN);
        sorter_send(OP_LOAD, 0);
        sorter_send(OP_LOAD, -1);
        sorter_send(OP_LOAD, 1);
        sorter_send(OP_LOAD, VAL_MAX);
        sorter_send(OP_LOAD, VAL_MIN);
        pull_beats(8);
    endtask

    task automatic test_reload_while_draining();
        load_set(4, MODE_WIDE);
        pull_beats(2);
        load_set(2, MODE_NARROW);
        pull_beats(3);
    endtask

    // full store, two overflow loads, then one sort, first values drained, rest discarded by the next load
    task automatic test_full_store();
        load_set(CAPACITY, MODE_MIXED);
        sorter_send(OP_LOAD, VAL_MAX);
        sorter_send(OP_LOAD, VAL_MIN);
        pull_beats(16);
    endtask

    task automatic test_random_sets();
        int start_count;
        int set_len;
        int pick;
        start_count = items_sent;
        while (items_sent - start_count < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 80)
                set_len = $urandom_range(1, 24);
            else if (pick < 96)
                set_len = $urandom_range(25, 100);
            else
                set_len = $urandom_range(101, 300);
            load_set(set_len, $urandom_range(MODE_WIDE, MODE_MIXED));
            pick = $urandom_range(0, 99);
            if (pick < 70)
            begin
                pull_beats(set_len);
                if ($urandom_range(0, 3) == 0)
                    pull_beats(1);
            end
            else if (pick < 90)
                pull_beats($urandom_range(0, set_len - 1));
            else
            begin
                repeat ($urandom_range(1, 8))
                    sorter_send(($urandom_range(0, 1) == 1) ? OP_PULL : OP_LOAD,
                                pick_value(MODE_MIXED));
            end
        end
    endtask

    // output stall pattern: ready runs, mostly short stalls, a few long ones
    initial
    begin
        int run;
        int pick;
        m_axis_tready = 1'b0;
        forever
        begin
            run = $urandom_range(1, 30);
            repeat (run)
            begin
                @(negedge clk);
                m_axis_tready <= 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 55)
                run = $urandom_range(1, 3);
            else if (pick < 90)
                run = 0;
            else
                run = $urandom_range(10, 50);
            repeat (run)
            begin
                @(negedge clk);
                m_axis_tready <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin : check_beat
        sorted_beat_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_sorted.size() == 0)
                report_mismatch($sformatf("unexpected beat data %0d last %0b status %0d",
                                          $signed(m_axis_tdata), m_axis_tlast, m_axis_tuser));
            else
            begin
                want = expected_sorted.pop_front();
                if (m_axis_tuser !== want.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              m_axis_tuser, want.status));
                if ($signed(m_axis_tdata) !== want.value)
                    report_mismatch($sformatf("value %0d, expected %0d",
                                              $signed(m_axis_tdata), want.value));
                if (m_axis_tlast !== want.last)
                    report_mismatch($sformatf("tlast %0b, expected %0b",
                                              m_axis_tlast, want.last));
            end
        end
    end

    initial
    begin
        #40000000;
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        rst_n          = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = OP_LOAD;
        mismatch_count = 0;
        items_sent     = 0;
        quiet_left     = 0;
        held_count     = 0;
        drain_idx      = 0;
        drain_phase    = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_empty_pull();
        test_single_value();
        test_extreme_values();
        test_reload_while_draining();
        test_full_store();
        test_random_sets();

        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (expected_sorted.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
